>>> hdl/car2_pkg.sv
// Shared widths, register indexes and reset constants for the radius-2 automaton raster.
package car2_pkg;

  localparam int unsigned COL_W       = 6;
  localparam int unsigned GEN_W       = 5;
  localparam int unsigned RULE_W      = 32;
  localparam int unsigned NB_W        = 5;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [GEN_W-1:0] GEN_COUNT_RESET = 5'd5;
  localparam logic [RULE_W-1:0] RULE_RESET     = 32'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RULE_WORD  = 1'b0,
    REG_GEN_COUNT  = 1'b1
  } cfg_reg_e;

endpackage

>>> hdl/radius2_cellular_automaton_raster.sv
// Radius-2 cellular automaton image generator, one cell per request in raster order.
//
// Input channel (in_valid_i/in_ready_o, restart_i): each request yields exactly one
// cell. restart_i set reloads the seed row before the cell is produced.
// Output channel (out_valid_o/out_ready_i): cell value, column, generation and the
// end-of-row and end-of-image flags of the produced cell.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_addr_i
// (0: rule word, 1: generation count) in the same cycle; write only while idle.
// A result shows in the output register in the cycle after its request is taken.
// Throughput: one cell per cycle while the output is not stalled; the next-row
// update and rule lookup are combinational, between the row and output registers.
// Stall: while the output register holds a result that is not taken, in_ready_o
// drops and the pending result holds; in_ready_o returns in the cycle it is taken.
// Reset: rule word 0, generation count 5, seed row with its live cell at the
// center, counters at zero, output register empty. No clearing pass is needed.
module radius2_cellular_automaton_raster #(
  parameter int unsigned MAX_GENERATIONS = 31
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [car2_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [car2_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            cell_value_o,
  output logic [car2_pkg::COL_W-1:0]      column_o,
  output logic [car2_pkg::GEN_W-1:0]      generation_o,
  output logic                            end_of_row_o,
  output logic                            end_of_image_o
);

  localparam int unsigned CELLS_W = 2 * MAX_GENERATIONS + 1;
  localparam int unsigned RESET_G = (MAX_GENERATIONS < 5) ? MAX_GENERATIONS : 5;
  localparam logic [car2_pkg::GEN_W-1:0] MAX_G = car2_pkg::GEN_W'(MAX_GENERATIONS);
  localparam logic [CELLS_W-1:0] SEED_RESET = CELLS_W'(1) << RESET_G;

  // Configuration registers
  logic [car2_pkg::RULE_W-1:0] rule_q;
  logic [car2_pkg::GEN_W-1:0]  gen_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q      <= car2_pkg::RULE_RESET;
      gen_count_q <= car2_pkg::GEN_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (car2_pkg::cfg_reg_e'(cfg_addr_i))
        car2_pkg::REG_RULE_WORD: rule_q      <= cfg_wdata_i[car2_pkg::RULE_W-1:0];
        car2_pkg::REG_GEN_COUNT: gen_count_q <= cfg_wdata_i[car2_pkg::GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Row and counter state
  logic [CELLS_W-1:0]         cur_q, cur_d;
  logic [CELLS_W-1:0]         next_q, next_d;
  logic [car2_pkg::COL_W-1:0] col_q, col_d;
  logic [car2_pkg::GEN_W-1:0] gen_q, gen_d;

  logic                       accept;
  logic [car2_pkg::GEN_W-1:0] g_eff;
  logic [7:0]                 width;
  logic [CELLS_W-1:0]         seed;
  logic [CELLS_W-1:0]         cur_eff, next_eff, next_wr;
  logic [car2_pkg::COL_W-1:0] col_eff;
  logic [car2_pkg::GEN_W-1:0] gen_eff;
  logic [car2_pkg::NB_W-1:0]  nb;
  logic                       cell_bit, new_bit, eor, eoi;

  logic                       out_valid_q;
  logic                       cell_q, eor_q, eoi_q;
  logic [car2_pkg::COL_W-1:0] col_out_q;
  logic [car2_pkg::GEN_W-1:0] gen_out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign g_eff = (gen_count_q > MAX_G) ? MAX_G : gen_count_q;
  assign width = {2'b00, g_eff, 1'b1};

  always_comb begin
    seed = '0;
    for (int i = 0; i < CELLS_W; i++) begin
      seed[i] = (car2_pkg::GEN_W'(i) == g_eff) && (i < 32);
    end
  end

  // Restart reloads the seed before this request's cell is formed
  assign cur_eff  = restart_i ? seed : cur_q;
  assign next_eff = restart_i ? '0 : next_q;
  assign col_eff  = restart_i ? '0 : col_q;
  assign gen_eff  = restart_i ? '0 : gen_q;

  always_comb begin
    logic [7:0] pos;
    cell_bit = 1'b0;
    nb       = '0;
    for (int i = 0; i < CELLS_W; i++) begin
      if (car2_pkg::COL_W'(i) == col_eff) begin
        cell_bit = cur_eff[i];
      end
    end
    // Neighbor c-2 lands in the most significant bit; cells past the row read dead
    for (int d = 0; d < 5; d++) begin
      pos = {2'b00, col_eff} + 8'(d) - 8'd2;
      for (int i = 0; i < CELLS_W; i++) begin
        if ((8'(i) == pos) && (8'(i) < width)) begin
          nb[4-d] = cur_eff[i];
        end
      end
    end
  end

  assign new_bit = rule_q[nb];

  always_comb begin
    next_wr = next_eff;
    for (int i = 0; i < CELLS_W; i++) begin
      if ((car2_pkg::COL_W'(i) == col_eff) && (8'(i) < width)) begin
        next_wr[i] = new_bit;
      end
    end
  end

  assign eor = {2'b00, col_eff} >= (width - 8'd1);
  assign eoi = eor && (gen_eff >= g_eff);

  always_comb begin
    cur_d  = cur_eff;
    next_d = next_wr;
    col_d  = col_eff + car2_pkg::COL_W'(1);
    gen_d  = gen_eff;
    if (eoi) begin
      cur_d  = seed;
      next_d = '0;
      col_d  = '0;
      gen_d  = '0;
    end else if (eor) begin
      cur_d  = next_wr;
      next_d = '0;
      col_d  = '0;
      gen_d  = gen_eff + car2_pkg::GEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= SEED_RESET;
      next_q <= '0;
      col_q  <= '0;
      gen_q  <= '0;
    end else if (accept) begin
      cur_q  <= cur_d;
      next_q <= next_d;
      col_q  <= col_d;
      gen_q  <= gen_d;
    end
  end

  // Output register: load on each request, hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q    <= cell_bit;
      col_out_q <= col_eff;
      gen_out_q <= gen_eff;
      eor_q     <= eor;
      eoi_q     <= eoi;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_value_o   = cell_q;
  assign column_o       = col_out_q;
  assign generation_o   = gen_out_q;
  assign end_of_row_o   = eor_q;
  assign end_of_image_o = eoi_q;

endmodule

>>> hdl/car2_checker.sv
// Port-level checks for the radius-2 automaton raster, bound to the top level.
module car2_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            restart_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            cell_value_o,
  input logic [car2_pkg::COL_W-1:0]      column_o,
  input logic [car2_pkg::GEN_W-1:0]      generation_o,
  input logic                            end_of_row_o,
  input logic                            end_of_image_o
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_value_o)
      && $stable(column_o) && $stable(generation_o)
      && $stable(end_of_row_o) && $stable(end_of_image_o))
    else $error("stalled result changed");

  // The last cell of the image is always the last of its row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> end_of_row_o)
    else $error("end of image without end of row");

  // An empty output register never blocks a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // A restart request produces the first cell of the seed row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && restart_i |=>
      out_valid_o && (column_o == '0) && (generation_o == '0))
    else $error("restart did not start at the seed row");

endmodule

bind radius2_cellular_automaton_raster car2_checker u_car2_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .restart_i      (restart_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .cell_value_o   (cell_value_o),
  .column_o       (column_o),
  .generation_o   (generation_o),
  .end_of_row_o   (end_of_row_o),
  .end_of_image_o (end_of_image_o)
);
